// File: rtl/pcmnd_pkg.sv
// Package with shared types and constants of the PCM sample normalizer.
`timescale 1ns / 1ps

package pcmnd_pkg;

  // Sample size codes of the sample_bits register.
  localparam logic [1:0] SizeBits8  = 2'd0;
  localparam logic [1:0] SizeBits16 = 2'd1;
  localparam logic [1:0] SizeBits24 = 2'd2;
  localparam logic [1:0] SizeBits32 = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] RegSampleBits  = 2'd0;
  localparam logic [1:0] RegIsFloat     = 2'd1;
  localparam logic [1:0] RegNumChannels = 2'd2;
  localparam logic [1:0] RegMonoMix     = 2'd3;

  // Widths of the configuration port and the sample word.
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned SampleW  = 32;

  // Float exponent limits: at or above FloatExpSat the magnitude is at least 1.0.
  localparam logic [7:0] FloatExpMax  = 8'd255;
  localparam logic [7:0] FloatExpSat  = 8'd127;
  localparam logic [7:0] FloatExpBase = 8'd126;

  // Saturation values in Q1.31.
  localparam logic [31:0] Q31Max = 32'h7FFF_FFFF;
  localparam logic [31:0] Q31Min = 32'h8000_0000;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StDiv,
    StFinish
  } state_e;

endpackage

// File: rtl/pcm_sample_normalizer_downmix_top.sv
// Top level of the PCM sample normalizer with optional mono downmix.
//
// Usage: one raw sample word enters per item on the input channel
// (in_valid_i / in_stall_o / raw_sample_i). It is converted to signed Q1.31
// from 8-bit unsigned, 16/24/32-bit signed or IEEE single float, as the
// configuration registers select. Without mono mixing each item yields one
// result with its channel index and a frame end flag. With mono mixing the
// samples of a frame are summed and the last one yields the average.
// Sequence: an item is converted in the cycle after it is accepted. A result
// without averaging is then written to the output register, and the next
// item is accepted once the sequencer has returned to idle; a mono item that
// does not end its frame passes through the same conversion state and yields
// no result. A mono frame end runs the serial divider over the sum magnitude,
// one quotient bit per cycle from a shared compare and subtract unit. Its
// average is then written to the output register, and no new item is accepted
// until the sequencer has returned to idle.
// Reset clears the registers to their defaults, the channel counter and the
// running sum. While the receiver stalls, the finished result holds in the
// output register; the next item with a result is converted and then waits,
// with the input stalled, until the output register is free.
`timescale 1ns / 1ps

module pcm_sample_normalizer_downmix_top #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_addr_i,
  input  logic [pcmnd_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [pcmnd_pkg::SampleW-1:0] raw_sample_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            sample_value_o,
  output logic [2:0]                    channel_o,
  output logic                          frame_end_o
);

  import pcmnd_pkg::*;

  localparam int unsigned CntW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned NW    = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned SumW  = 33 + $clog2(MAX_CHANNELS);
  localparam int unsigned IterW = $clog2(SumW + 1);
  localparam logic [4:0]  MaxCh = 5'(MAX_CHANNELS);

  // Configuration registers.
  logic [1:0] sample_bits_q;
  logic       is_float_q;
  logic [3:0] num_channels_q;
  logic       mono_mix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_bits_q  <= SizeBits16;
      is_float_q     <= 1'b0;
      num_channels_q <= 4'd2;
      mono_mix_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegSampleBits:  sample_bits_q  <= cfg_wdata_i[1:0];
        RegIsFloat:     is_float_q     <= cfg_wdata_i[0];
        RegNumChannels: num_channels_q <= cfg_wdata_i[3:0];
        RegMonoMix:     mono_mix_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // State and datapath registers.
  state_e                state_q, state_d;
  logic [SampleW-1:0]    raw_q;
  logic [CntW-1:0]       count_q, count_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [SumW-1:0]       dvd_q, dvd_d;
  logic [NW-1:0]         rem_q, rem_d;
  logic [NW-1:0]         div_n_q, div_n_d;
  logic                  div_neg_q, div_neg_d;
  logic [IterW-1:0]      iter_q, iter_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_value_q, out_value_d;
  logic [2:0]  out_ch_q, out_ch_d;
  logic        out_end_q, out_end_d;

  logic in_accept;
  logic out_free;

  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign sample_value_o = out_value_q;
  assign channel_o      = out_ch_q;
  assign frame_end_o    = out_end_q;

  // Effective channel count, clamped to 1..MAX_CHANNELS.
  logic [4:0]    n_clamp;
  logic [NW-1:0] n_eff;
  logic          last;

  always_comb begin
    n_clamp = {1'b0, num_channels_q};
    if (n_clamp == 5'd0) begin
      n_clamp = 5'd1;
    end else if (n_clamp > MaxCh) begin
      n_clamp = MaxCh;
    end
    n_eff = NW'(n_clamp);
    last  = (5'(count_q) + 5'd1) >= n_clamp;
  end

  // Float to Q1.31 conversion with saturation; a NaN gives zero.
  logic        f_neg;
  logic [7:0]  f_exp;
  logic [22:0] f_man;
  logic [7:0]  f_shamt;
  logic [30:0] f_mag;
  logic [31:0] f_val;

  always_comb begin
    f_neg   = raw_q[31];
    f_exp   = raw_q[30:23];
    f_man   = raw_q[22:0];
    f_shamt = FloatExpBase - f_exp;
    f_mag   = '0;
    if (f_exp != 8'd0 && f_exp < FloatExpSat && f_shamt < 8'd31) begin
      f_mag = {1'b1, f_man, 7'b0} >> f_shamt[4:0];
    end
    priority if (f_exp == FloatExpMax && f_man != 23'd0) begin
      f_val = '0;
    end else if (f_exp >= FloatExpSat) begin
      f_val = f_neg ? Q31Min : Q31Max;
    end else begin
      f_val = f_neg ? (32'd0 - {1'b0, f_mag}) : {1'b0, f_mag};
    end
  end

  // Integer formats and format selection.
  logic [31:0] conv_val;

  always_comb begin
    unique case (sample_bits_q)
      SizeBits8:  conv_val = {~raw_q[7], raw_q[6:0], 24'd0};
      SizeBits16: conv_val = {raw_q[15:0], 16'd0};
      SizeBits24: conv_val = {raw_q[23:0], 8'd0};
      SizeBits32: conv_val = is_float_q ? f_val : raw_q;
      default:    conv_val = raw_q;
    endcase
  end

  // Running sum including the current sample, and its magnitude.
  logic signed [SumW-1:0] sum_new;
  logic [SumW-1:0]        sum_mag;

  always_comb begin
    sum_new = sum_q + {{(SumW - 32){conv_val[31]}}, conv_val};
    sum_mag = sum_new[SumW-1] ? (SumW'(0) - sum_new) : sum_new;
  end

  // Shared compare and subtract step of the serial divider.
  logic [NW:0] trial;
  logic        trial_ge;

  always_comb begin
    trial    = {rem_q, dvd_q[SumW-1]};
    trial_ge = trial >= {1'b0, div_n_q};
  end

  // Quotient with its sign restored.
  logic [31:0] quot_val;
  assign quot_val = div_neg_q ? (32'd0 - dvd_q[31:0]) : dvd_q[31:0];

  // Next state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          state_d = StConv;
        end
      end
      StConv: begin
        if (mono_mix_q) begin
          state_d = last ? StDiv : StIdle;
        end else if (out_free) begin
          state_d = StIdle;
        end
      end
      StDiv: begin
        if (iter_q == IterW'(SumW - 1)) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath and output register updates.
  always_comb begin
    count_d     = count_q;
    sum_d       = sum_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    div_n_d     = div_n_q;
    div_neg_d   = div_neg_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    out_ch_d    = out_ch_q;
    out_end_d   = out_end_q;
    unique case (state_q)
      StIdle: ;
      StConv: begin
        if (mono_mix_q) begin
          if (last) begin
            // Frame end: start the divider on the sum magnitude.
            count_d   = '0;
            sum_d     = '0;
            dvd_d     = sum_mag;
            rem_d     = '0;
            div_n_d   = n_eff;
            div_neg_d = sum_new[SumW-1];
            iter_d    = '0;
          end else begin
            count_d = count_q + CntW'(1);
            sum_d   = sum_new;
          end
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = conv_val;
          out_ch_d    = 3'(count_q);
          out_end_d   = last;
          if (last) begin
            count_d = '0;
            sum_d   = '0;
          end else begin
            count_d = count_q + CntW'(1);
          end
        end
      end
      StDiv: begin
        // One quotient bit per cycle, shifted into the dividend register.
        rem_d  = trial_ge ? NW'(trial - {1'b0, div_n_q}) : trial[NW-1:0];
        dvd_d  = {dvd_q[SumW-2:0], trial_ge};
        iter_d = iter_q + IterW'(1);
      end
      StFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = quot_val;
          out_ch_d    = '0;
          out_end_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      sum_q       <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      raw_q <= raw_sample_i;
    end
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    div_n_q     <= div_n_d;
    div_neg_q   <= div_neg_d;
    out_value_q <= out_value_d;
    out_ch_q    <= out_ch_d;
    out_end_q   <= out_end_d;
  end

endmodule
